/* src/icdf_pkg.sv */
`timescale 1ns / 1ps

package icdf_pkg;

  localparam int unsigned IDX_W  = 10;
  localparam int unsigned MASS_W = 32;
  localparam int unsigned SUM_W  = 40;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_QUERY  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_SAT   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_COMPARE
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [MASS_W-1:0] mass_value;
    logic [SUM_W-1:0]  query_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] cell_index;
    logic [1:0]       status;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic direct;       // finish a load, unused code or empty query now
    logic search_init;  // latch the query and open the search window
    logic probe;        // read the sums at mid and mid-1
    logic exhaust;      // window is empty: answer with the last index
    logic compare;      // judge the registered sums and narrow the window
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_search;
    logic exhausted;
    logic found;
  } dp_stat_t;

endpackage

/* src/icdf_ctrl.sv */
`timescale 1ns / 1ps

module icdf_ctrl
  import icdf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  dp_stat_t  stat_i,
  output logic      busy,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (stat_i.need_search) begin
            cmd_o.search_init = 1'b1;
            state_d           = S_PROBE;
          end else begin
            cmd_o.direct = 1'b1;
          end
        end
      end
      S_PROBE: begin
        if (stat_i.exhausted) begin
          cmd_o.exhaust = 1'b1;
          state_d       = S_IDLE;
        end else begin
          cmd_o.probe = 1'b1;
          state_d     = S_COMPARE;
        end
      end
      S_COMPARE: begin
        cmd_o.compare = 1'b1;
        state_d       = stat_i.found ? S_IDLE : S_PROBE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

/* src/icdf_dpath.sv */
`timescale 1ns / 1ps

module icdf_dpath
  import icdf_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  item_i,
  input  ctrl_cmd_t cmd_i,
  output dp_stat_t  stat_o,
  output logic      done_o,
  output out_item_t result_o
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [SUM_W-1:0] mem [TABLE_DEPTH];

  logic [CW-1:0]    count_q, count_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             done_q, done_d;
  out_item_t        res_q, res_d;

  logic [SUM_W-1:0] qry_q;
  logic [CW-1:0]    lo_q, hp1_q;   // window is [lo, hp1 - 1]
  logic [IW-1:0]    mid_q;
  logic [SUM_W-1:0] rd_a_q, rd_b_q;

  logic [CW:0]      mid_sum;
  logic [IW-1:0]    mid, mid_m1;
  logic [SUM_W:0]   add_ext;
  logic             full;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic [SUM_W-1:0] wr_data;
  logic             go_right, go_left;

  assign full    = (count_q == DEPTH_C);
  assign add_ext = {1'b0, sum_q} + {{(SUM_W + 1 - MASS_W){1'b0}}, item_i.mass_value};

  // Midpoint of the open window; the sum never goes negative while lo < hp1.
  assign mid_sum = {1'b0, lo_q} + {1'b0, hp1_q} - (CW + 1)'(1);
  assign mid     = mid_sum[IW:1];
  assign mid_m1  = mid - IW'(1);

  assign go_right = (qry_q > rd_a_q);
  assign go_left  = !go_right && (mid_q != '0) && (qry_q < rd_b_q);

  assign stat_o.need_search = (item_i.func == FUNC_QUERY) && (count_q != '0);
  assign stat_o.exhausted   = (lo_q >= hp1_q);
  assign stat_o.found       = !go_right && !go_left;

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    done_d  = 1'b0;
    res_d   = res_q;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (cmd_i.direct) begin
      done_d = 1'b1;
      res_d  = '{cell_index: '0, status: ST_OK};
      case (item_i.func)
        FUNC_START: begin
          sum_d   = SUM_W'(item_i.mass_value);
          count_d = CW'(1);
          wr_en   = 1'b1;
          wr_data = SUM_W'(item_i.mass_value);
        end
        FUNC_APPEND: begin
          if (full) begin
            res_d.cell_index = IDX_W'(TABLE_DEPTH - 1);
            res_d.status     = ST_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = count_q[IW-1:0];
            if (add_ext[SUM_W]) begin
              wr_data      = SUM_MAX;
              res_d.status = ST_SAT;
            end else begin
              wr_data = add_ext[SUM_W-1:0];
            end
            sum_d            = wr_data;
            count_d          = count_q + CW'(1);
            res_d.cell_index = IDX_W'(count_q);
          end
        end
        FUNC_QUERY: begin
          res_d.status = ST_EMPTY;
        end
        default: begin
        end
      endcase
    end else if (cmd_i.exhaust) begin
      done_d           = 1'b1;
      res_d.cell_index = IDX_W'(count_q - CW'(1));
      res_d.status     = ST_OK;
    end else if (cmd_i.compare && stat_o.found) begin
      done_d           = 1'b1;
      res_d.cell_index = IDX_W'(mid_q);
      res_d.status     = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cmd_i.search_init) begin
      qry_q <= item_i.query_value;
      lo_q  <= '0;
      hp1_q <= count_q;
    end else if (cmd_i.compare) begin
      if (go_right) begin
        lo_q <= CW'(mid_q) + CW'(1);
      end else if (go_left) begin
        hp1_q <= CW'(mid_q);
      end
    end
    if (cmd_i.probe) begin
      mid_q <= mid;
    end
  end

  // Table memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.probe) begin
      rd_a_q <= mem[mid];
      rd_b_q <= mem[mid_m1];
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

/* src/inverse_cdf_cell_sampler.sv */
`timescale 1ns / 1ps
// Channel   Handshake              Payload               Notes
// input     start in, busy out     item_i   (in_item_t)  taken when start & !busy
// result    done_o strobe          result_o (out_item_t) valid for one cycle only
//
// Loads, unused codes and queries on an empty table need no search: the
// result shows on the cycle after the item is taken and busy never rises.
// A query runs a binary search; each probe reads the sums at mid and mid-1
// from the two-port table memory, then compares. A query makes at most
// ceil(log2(n+1)) probes for n loaded cells, and its result shows in the
// cycle in which busy falls.
// Reset is asynchronous and active low; it empties the table (count and
// running sum to zero). The receiver cannot stall; every result is taken.

module inverse_cdf_cell_sampler
  import icdf_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item_i,
  output logic      done_o,
  output out_item_t result_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // The controller only acts on start while idle, so an item is taken exactly
  // when start is high and busy is low.
  icdf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // The datapath holds the cumulative-sum table, the running sum, the entry
  // count, the search window and the registered result.
  icdf_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

/* src/icdf_checker.sv */
`timescale 1ns / 1ps

module icdf_checker
  import icdf_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input in_item_t  item_i,
  input logic      done_o,
  input out_item_t result_o
);

  logic accept;
  assign accept = start && !busy;

  // A restart always answers on the next cycle with index zero and ok.
  a_start_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (item_i.func == FUNC_START) |=>
      done_o && (result_o.cell_index == '0) && (result_o.status == ST_OK))
    else $error("restart item did not give index zero with ok status");

  // An append answers on the next cycle and never reports an empty table.
  a_append_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (item_i.func == FUNC_APPEND) |=>
      done_o && (result_o.status != ST_EMPTY))
    else $error("append item gave no result or an empty status");

  // A query either reports an empty table at once or starts searching.
  a_query_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (item_i.func == FUNC_QUERY) |=>
      (done_o && (result_o.status == ST_EMPTY)) || (busy && !done_o))
    else $error("query neither answered empty nor entered the search");

  // The end of a search always delivers its result.
  a_search_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o && (result_o.status == ST_OK))
    else $error("search ended without an ok result");

endmodule

bind inverse_cdf_cell_sampler icdf_checker u_icdf_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .item_i   (item_i),
  .done_o   (done_o),
  .result_o (result_o)
);

/* dv/inverse_cdf_cell_sampler_test.sv */
`timescale 1ns / 1ps

module inverse_cdf_cell_sampler_test;
  import icdf_pkg::*;

  localparam int unsigned DEPTH       = 1024;
  localparam int          ITEM_TARGET = 1700;
  // A query's search is bounded by the table depth, so this many cycles with
  // no item taken and no result seen means the block has hung.
  localparam int          STALL_LIMIT = 4000;
  localparam int          TAIL_CYCLES = 40;

  // The package names the three live codes; the fourth is a no-op.
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  logic      busy;
  in_item_t  item_i = '0;
  logic      done_o;
  out_item_t result_o;

  inverse_cdf_cell_sampler #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Items waiting to be driven. A set pause flag makes the driver hold that
  // item back until every result owed so far has come out of the block.
  in_item_t  pending_cmds_q[$];
  bit        pause_flags_q[$];
  out_item_t expected_cells_q[$];

  // Handshake counters. Both are updated with nonblocking assignments so
  // that every process sees the values from before the current edge.
  int items_accepted = 0;
  int results_seen   = 0;
  int stall_cycles   = 0;
  int mismatches     = 0;

  // Predicted state of the block: the stored cumulative sums, how many
  // cells are loaded and the running sum that the next append adds to.
  logic [SUM_W-1:0] cdf_sums [DEPTH];
  int               cdf_count = 0;
  logic [SUM_W-1:0] cdf_total = '0;

  // A second copy of the sums, kept while the stimulus is planned, so that
  // queries can be aimed at, next to, or past the stored values.
  logic [SUM_W-1:0] plan_sums[$];
  logic [SUM_W-1:0] plan_total = '0;

  function automatic logic [SUM_W-1:0] add_saturating(logic [SUM_W-1:0] acc,
                                                      logic [MASS_W-1:0] mass);
    logic [SUM_W:0] wide;
    wide = {1'b0, acc} + mass;
    return wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
  endfunction

  // Binary search over the loaded sums. It stops at the first probe whose
  // sum is not below the query while the sum before it is not above it; an
  // exhausted search answers with the last loaded cell.
  function automatic int search_cell(logic [SUM_W-1:0] q, int n);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = n - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (q > cdf_sums[mid]) begin
        lo = mid + 1;
      end else if (mid > 0 && q < cdf_sums[mid-1]) begin
        hi = mid - 1;
      end else begin
        return mid;
      end
    end
    return n - 1;
  endfunction

  // Applies one accepted item to the predicted state and returns the
  // result that the block owes for it.
  function automatic out_item_t sample_cell(in_item_t cmd);
    out_item_t res;
    int        hit;
    res.cell_index = '0;
    res.status     = ST_OK;
    case (cmd.func)
      FUNC_START: begin
        cdf_total   = {{(SUM_W-MASS_W){1'b0}}, cmd.mass_value};
        cdf_sums[0] = cdf_total;
        cdf_count   = 1;
      end
      FUNC_APPEND: begin
        if (cdf_count >= DEPTH) begin
          // A full table drops the mass and points at the last cell.
          res.cell_index = IDX_W'(DEPTH - 1);
          res.status     = ST_FULL;
        end else begin
          // After reset the running sum is zero, so an append with no
          // start simply lands in entry 0.
          if ({1'b0, cdf_total} + cmd.mass_value > {1'b0, SUM_MAX}) begin
            res.status = ST_SAT;
          end
          cdf_total           = add_saturating(cdf_total, cmd.mass_value);
          cdf_sums[cdf_count] = cdf_total;
          res.cell_index      = cdf_count[IDX_W-1:0];
          cdf_count++;
        end
      end
      FUNC_QUERY: begin
        if (cdf_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          hit            = search_cell(cmd.query_value, cdf_count);
          res.cell_index = hit[IDX_W-1:0];
        end
      end
      default: begin
        // The unused code leaves the state alone and answers with zeros.
      end
    endcase
    return res;
  endfunction

  function automatic logic [SUM_W-1:0] rand_sum();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[SUM_W-1:0];
  endfunction

  // Masses lean toward zero (repeated sums), the top value and values of at
  // most 2^24, with the rest spread over the whole 32-bit range.
  function automatic logic [MASS_W-1:0] pick_mass();
    case ($urandom_range(9))
      0:       return '0;
      1:       return {MASS_W{1'b1}};
      2, 3, 4: return $urandom_range(32'h0100_0000);
      default: return $urandom;
    endcase
  endfunction

  // Query values land on a stored sum, one step to either side of it, at
  // the extremes, anywhere, or anywhere up to the last sum.
  function automatic logic [SUM_W-1:0] pick_query();
    int unsigned    k;
    logic [SUM_W:0] span;
    logic [SUM_W:0] r;
    if (plan_sums.size() == 0) begin
      return rand_sum();
    end
    k = $urandom_range(plan_sums.size() - 1);
    case ($urandom_range(7))
      0:       return plan_sums[k];
      1:       return plan_sums[k] + 1;
      2:       return plan_sums[k] - 1;
      3:       return '0;
      4:       return SUM_MAX;
      5:       return rand_sum();
      default: begin
        span = {1'b0, plan_sums[plan_sums.size()-1]} + 1;
        r    = {1'b0, rand_sum()} % span;
        return r[SUM_W-1:0];
      end
    endcase
  endfunction

  // Queues one item and keeps the planning copy of the sums in step.
  task automatic queue_item(logic [1:0] f, logic [MASS_W-1:0] m,
                            logic [SUM_W-1:0] q, bit pause);
    in_item_t cmd;
    cmd.func        = f;
    cmd.mass_value  = m;
    cmd.query_value = q;
    pending_cmds_q.push_back(cmd);
    pause_flags_q.push_back(pause);
    case (f)
      FUNC_START: begin
        plan_sums.delete();
        plan_total = {{(SUM_W-MASS_W){1'b0}}, m};
        plan_sums.push_back(plan_total);
      end
      FUNC_APPEND: begin
        if (plan_sums.size() < DEPTH) begin
          plan_total = add_saturating(plan_total, m);
          plan_sums.push_back(plan_total);
        end
      end
      default: begin
      end
    endcase
  endtask

  // The sender idles at random, except for a stretch in the middle of the
  // run where items follow each other as fast as the block takes them.
  function automatic int idle_percent();
    return (items_accepted >= 600 && items_accepted < 900) ? 0 : 22;
  endfunction

  // Driver. An item is taken at an edge where start is high and busy is
  // low; an item that is shown while busy is high stays on the bus until
  // it is taken. Start is assigned at most once per edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_cells_q.push_back(sample_cell(item_i));
        items_accepted <= items_accepted + 1;
      end
      if (!(start && busy)) begin
        if (pending_cmds_q.size() == 0) begin
          start <= 1'b0;
        end else if (pause_flags_q[0] &&
                     items_accepted + (start && !busy) != results_seen + done_o) begin
          // Hold back until the block has delivered everything it owes.
          start <= 1'b0;
        end else if ($urandom_range(99) < idle_percent()) begin
          start <= 1'b0;
        end else begin
          start  <= 1'b1;
          item_i <= pending_cmds_q.pop_front();
          void'(pause_flags_q.pop_front());
        end
      end
    end
  end

  // Monitor. A result is on the bus for one cycle only and is taken at the
  // edge that ends that cycle; it is checked against the oldest prediction.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && done_o) begin
      results_seen <= results_seen + 1;
      if (results_seen >= items_accepted) begin
        $error("unexpected result: cell_index %0d, status %0d",
               result_o.cell_index, result_o.status);
        mismatches++;
      end else begin
        want = expected_cells_q.pop_front();
        if (result_o.cell_index !== want.cell_index) begin
          $error("cell_index: expected %0d, got %0d", want.cell_index,
                 result_o.cell_index);
          mismatches++;
        end
        if (result_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result_o.status);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither side moves an item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      stall_cycles <= ((start && !busy) || done_o) ? 0 : stall_cycles + 1;
    end
  end

  initial begin
    int phase_no;
    int n_cells;
    bit pause;

    // Directed part, on the empty table that reset leaves behind: queries
    // and the unused code before anything is loaded, appends with no start,
    // zero and full-scale masses, and queries at the extremes.
    queue_item(FUNC_QUERY, '0, '0, 1'b0);
    queue_item(FUNC_QUERY, {MASS_W{1'b1}}, SUM_MAX, 1'b0);
    queue_item(FUNC_UNUSED, {MASS_W{1'b1}}, SUM_MAX, 1'b0);
    queue_item(FUNC_APPEND, 32'h0500_0000, '0, 1'b0);
    queue_item(FUNC_APPEND, '0, '0, 1'b0);
    queue_item(FUNC_APPEND, {MASS_W{1'b1}}, '0, 1'b0);
    queue_item(FUNC_QUERY, '0, '0, 1'b0);
    queue_item(FUNC_QUERY, '0, plan_sums[0], 1'b0);
    queue_item(FUNC_QUERY, '0, plan_sums[0] + 1, 1'b0);
    queue_item(FUNC_QUERY, '0, plan_sums[2], 1'b0);
    // Past the last sum the search runs out and answers with the last cell.
    queue_item(FUNC_QUERY, '0, SUM_MAX, 1'b0);
    // A restart on a zero mass, held back until the queries above are done.
    queue_item(FUNC_START, '0, SUM_MAX, 1'b1);
    repeat (4) queue_item(FUNC_APPEND, $urandom_range(32'h0100_0000), rand_sum(), 1'b0);
    for (int k = 0; k < 5; k++) begin
      queue_item(FUNC_QUERY, $urandom, plan_sums[k], 1'b0);
    end
    queue_item(FUNC_QUERY, $urandom, plan_sums[4] + 1, 1'b0);
    queue_item(FUNC_UNUSED, '0, '0, 1'b0);

    // Random part. Most phases build a fresh table and query it; some are
    // plain noise. One phase fills the whole table with full-range masses,
    // which also drives the running sum into saturation, and then pushes
    // appends into the full table.
    phase_no = 0;
    while (pending_cmds_q.size() < ITEM_TARGET) begin
      pause = (phase_no == 1) || ($urandom_range(5) == 0);
      if (phase_no == 4) begin
        queue_item(FUNC_START, $urandom, rand_sum(), pause);
        repeat (DEPTH + 2) queue_item(FUNC_APPEND, $urandom, rand_sum(), 1'b0);
        repeat (12) queue_item(FUNC_QUERY, $urandom, pick_query(), 1'b0);
        queue_item(FUNC_UNUSED, $urandom, rand_sum(), 1'b0);
      end else if ($urandom_range(99) < 85) begin
        n_cells = ($urandom_range(9) == 0) ? $urandom_range(60, 250) : $urandom_range(0, 24);
        queue_item(FUNC_START, pick_mass(), rand_sum(), pause);
        repeat (n_cells) queue_item(FUNC_APPEND, pick_mass(), rand_sum(), 1'b0);
        repeat ($urandom_range(3, 12)) begin
          case ($urandom_range(9))
            0:       queue_item(FUNC_UNUSED, $urandom, rand_sum(), 1'b0);
            1:       queue_item(FUNC_APPEND, pick_mass(), rand_sum(), 1'b0);
            default: queue_item(FUNC_QUERY, $urandom, pick_query(), 1'b0);
          endcase
        end
      end else begin
        repeat ($urandom_range(2, 8)) begin
          queue_item(2'($urandom_range(3)), $urandom, rand_sum(), pause);
          pause = 1'b0;
        end
      end
      phase_no++;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every item has gone in and every result has come out,
    // checking on the falling edge where all edge activity has settled.
    do begin
      @(negedge clk_i);
    end while (!(pending_cmds_q.size() == 0 && !start && items_accepted == results_seen)
               && stall_cycles < STALL_LIMIT);

    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: %0d items taken, %0d results seen", items_accepted,
               results_seen);
      $display("== FAIL ==");
    end else begin
      // Any late or extra result still gets caught by the monitor here.
      repeat (TAIL_CYCLES) @(posedge clk_i);
      if (mismatches == 0 && items_accepted == results_seen) begin
        $display("== PASS ==");
      end else begin
        $display("== FAIL ==");
      end
    end
    $finish;
  end

endmodule
